@@ hdl/assert_macros.svh @@
// Clocked assertion helpers, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(lbl, clk, rst, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Implication checked in the next cycle.
`define CHK_NEXT(lbl, clk, rst, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

@@ hdl/pru_pkg.sv @@
package pru_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BYTE_SHIFT    = 3;

  // Configuration register widths and indexes
  localparam int COLUMNS_W    = 13;
  localparam int COMPONENTS_W = 3;
  localparam int COMP_BITS_W  = 5;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COLUMNS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOUR_COMPONENTS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENT_BITS    = 2'd2;

  // Derived size arithmetic
  localparam int PIX_BITS_W = COMPONENTS_W + COMP_BITS_W;
  localparam int ROW_BITS_W = COLUMNS_W + PIX_BITS_W;
  localparam int ROW_RAW_W  = ROW_BITS_W + 1 - BYTE_SHIFT;
  localparam int PIX_RAW_W  = PIX_BITS_W + 1 - BYTE_SHIFT;

  localparam int CFG_SETTLE_W = 2;
  localparam logic [CFG_SETTLE_W-1:0] CFG_SETTLE_CYCLES = 2'd2;

  // Filter types
  localparam logic [2:0] FILTER_NONE  = 3'd0;
  localparam logic [2:0] FILTER_SUB   = 3'd1;
  localparam logic [2:0] FILTER_UP    = 3'd2;
  localparam logic [2:0] FILTER_AVG   = 3'd3;
  localparam logic [2:0] FILTER_PAETH = 3'd4;
  localparam logic [7:0] LAST_FILTER_TYPE = 8'd4;

  // Fault codes
  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_FILTER = 2'd1;
  localparam logic [1:0] FAULT_ROWS   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       end_of_image;
    logic [1:0] fault_code;
  } pixel_res_t;

endpackage

@@ hdl/png_row_unfilter.sv @@
// PNG row unfilter: turns a filtered, decompressed byte stream back into image bytes.
// Input channel byte_valid/byte_stall/byte_req: one stream byte per request, filter
// type bytes included; last_byte marks the end of the stream.
// Output channel pixel_valid/pixel_stall/pixel_res: one result per data byte, plus a
// fault result for a bad filter type or for a stream that stops mid-row.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data: write only while idle.
// After its request is taken, a result is registered in the unfilter stage, then in the output register.
// Throughput: one byte per cycle unless the input stalls, set by the single read port of
// the row memory (read at accept, written back one stage later) and one unfilter stage.
// After reset and after each configuration write the input stalls while the row and
// pixel sizes are recomputed. Reset starts a new stream; the row memory is not cleared,
// since the first row of every stream ignores it.
// When the receiver stalls, the output register holds its result and the unfilter
// stage behind it holds too; the input then stalls in the same cycle.
`include "assert_macros.svh"

module png_row_unfilter #(
  parameter int MAX_ROW_BYTES   = 4096,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  pru_pkg::byte_req_t                byte_req,
  output logic                              pixel_valid,
  input  logic                              pixel_stall,
  output pru_pkg::pixel_res_t               pixel_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pru_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int SW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int PBW = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int CW  = (PW > PBW) ? PW : PBW;

  // ---------------------------------------------------------------- config
  logic [pru_pkg::COLUMNS_W-1:0]    pixel_columns;
  logic [pru_pkg::COMPONENTS_W-1:0] colour_components;
  logic [pru_pkg::COMP_BITS_W-1:0]  component_bits;
  logic [pru_pkg::CFG_SETTLE_W-1:0] settle;
  logic                             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_columns     <= pru_pkg::COLUMNS_W'(1);
      colour_components <= pru_pkg::COMPONENTS_W'(1);
      component_bits    <= pru_pkg::COMP_BITS_W'(8);
      settle            <= pru_pkg::CFG_SETTLE_CYCLES;
    end else begin
      if (cfg_wr) begin
        settle <= pru_pkg::CFG_SETTLE_CYCLES;
        unique case (cfg_index)
          pru_pkg::CFG_PIXEL_COLUMNS:
            pixel_columns <= cfg_data[pru_pkg::COLUMNS_W-1:0];
          pru_pkg::CFG_COLOUR_COMPONENTS:
            colour_components <= cfg_data[pru_pkg::COMPONENTS_W-1:0];
          pru_pkg::CFG_COMPONENT_BITS:
            component_bits <= cfg_data[pru_pkg::COMP_BITS_W-1:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  // Two-stage size derivation: bits per pixel, then row and pixel bytes
  logic [pru_pkg::PIX_BITS_W-1:0] pix_bits;
  logic [pru_pkg::ROW_BITS_W-1:0] row_bits;
  logic [pru_pkg::ROW_BITS_W:0]   row_sum;
  logic [pru_pkg::PIX_BITS_W:0]   pix_sum;
  logic [pru_pkg::ROW_RAW_W-1:0]  row_raw;
  logic [pru_pkg::PIX_RAW_W-1:0]  pix_raw;
  logic [PW-1:0]                  row_bytes, row_bytes_next;
  logic [PBW-1:0]                 pix_bytes, pix_bytes_next;

  always_comb begin
    row_bits = pru_pkg::ROW_BITS_W'(pixel_columns) * pru_pkg::ROW_BITS_W'(pix_bits);
    row_sum  = {1'b0, row_bits} + (pru_pkg::ROW_BITS_W+1)'(pru_pkg::BITS_PER_BYTE - 1);
    pix_sum  = {1'b0, pix_bits} + (pru_pkg::PIX_BITS_W+1)'(pru_pkg::BITS_PER_BYTE - 1);
    row_raw  = row_sum[pru_pkg::ROW_BITS_W:pru_pkg::BYTE_SHIFT];
    pix_raw  = pix_sum[pru_pkg::PIX_BITS_W:pru_pkg::BYTE_SHIFT];
    if (row_raw == '0)
      row_bytes_next = PW'(1);
    else if (32'(row_raw) > MAX_ROW_BYTES)
      row_bytes_next = PW'(MAX_ROW_BYTES);
    else
      row_bytes_next = PW'(row_raw);
    if (pix_raw == '0)
      pix_bytes_next = PBW'(1);
    else if (32'(pix_raw) > MAX_PIXEL_BYTES)
      pix_bytes_next = PBW'(MAX_PIXEL_BYTES);
    else
      pix_bytes_next = PBW'(pix_raw);
  end

  always_ff @(posedge clk) begin
    pix_bits  <= pru_pkg::PIX_BITS_W'(colour_components) *
                 pru_pkg::PIX_BITS_W'(component_bits);
    row_bytes <= row_bytes_next;
    pix_bytes <= pix_bytes_next;
  end

  // ---------------------------------------------------------------- row parser
  logic [PW-1:0] byte_position, byte_position_next;
  logic [2:0]    row_filter, row_filter_next;
  logic          first_row, first_row_next;
  logic          discarding, discarding_next;
  logic [SW-1:0] mod_cnt [MAX_PIXEL_BYTES];
  logic          cnt_step, cnt_clr;
  logic          take, s1_load, s1_load_data;
  logic [1:0]    load_fault;
  logic          load_end, row_done, left_ok;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] slot_sel;

  // Unfilter stage
  logic          s1_valid, s1_adv, s1_data, s1_end, s1_last, s1_row_done;
  logic          s1_first, s1_left_ok;
  logic [1:0]    s1_fault;
  logic [7:0]    s1_byte;
  logic [2:0]    s1_filter;
  logic [SW-1:0] s1_slot;
  logic [AW-1:0] s1_addr;

  logic          out_valid;
  pru_pkg::pixel_res_t out_res, res_next;

  assign s1_adv     = s1_valid && (!out_valid || !pixel_stall);
  assign byte_stall = (settle != '0) || (s1_valid && !s1_adv);
  assign take       = byte_valid && !byte_stall;

  assign row_done = (CW'(byte_position) >= CW'(row_bytes));
  assign left_ok  = (CW'(byte_position) > CW'(pix_bytes));
  assign rd_addr  = AW'(byte_position - PW'(1));
  assign slot_sel = mod_cnt[SW'(pix_bytes - PBW'(1))];

  always_comb begin
    byte_position_next = byte_position;
    row_filter_next    = row_filter;
    first_row_next     = first_row;
    discarding_next    = discarding;
    s1_load            = 1'b0;
    s1_load_data       = 1'b0;
    load_fault         = pru_pkg::FAULT_NONE;
    load_end           = byte_req.last_byte;
    cnt_step           = 1'b0;
    cnt_clr            = 1'b0;
    if (take) begin
      if (discarding) begin
        if (byte_req.last_byte) begin
          byte_position_next = '0;
          row_filter_next    = pru_pkg::FILTER_NONE;
          first_row_next     = 1'b1;
          discarding_next    = 1'b0;
        end
      end else if (byte_position == '0) begin
        if (byte_req.data_byte > pru_pkg::LAST_FILTER_TYPE) begin
          s1_load    = 1'b1;
          load_fault = pru_pkg::FAULT_FILTER;
          if (byte_req.last_byte) begin
            row_filter_next = pru_pkg::FILTER_NONE;
            first_row_next  = 1'b1;
          end else begin
            discarding_next = 1'b1;
          end
        end else if (byte_req.last_byte) begin
          s1_load         = 1'b1;
          load_fault      = pru_pkg::FAULT_ROWS;
          row_filter_next = pru_pkg::FILTER_NONE;
          first_row_next  = 1'b1;
        end else begin
          row_filter_next    = byte_req.data_byte[2:0];
          byte_position_next = PW'(1);
        end
      end else begin
        s1_load      = 1'b1;
        s1_load_data = 1'b1;
        if (row_done || byte_req.last_byte) begin
          byte_position_next = '0;
          cnt_clr            = 1'b1;
          if (row_done)
            first_row_next = 1'b0;
        end else begin
          byte_position_next = byte_position + 1'b1;
          cnt_step           = 1'b1;
        end
        if (byte_req.last_byte) begin
          row_filter_next = pru_pkg::FILTER_NONE;
          first_row_next  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      row_filter    <= pru_pkg::FILTER_NONE;
      first_row     <= 1'b1;
      discarding    <= 1'b0;
      for (int m = 0; m < MAX_PIXEL_BYTES; m++)
        mod_cnt[m] <= '0;
    end else begin
      byte_position <= byte_position_next;
      row_filter    <= row_filter_next;
      first_row     <= first_row_next;
      discarding    <= discarding_next;
      // one running j mod (m+1) per possible pixel size, so a size change never needs a divide
      for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
        if (cnt_clr)
          mod_cnt[m] <= '0;
        else if (cnt_step)
          mod_cnt[m] <= (mod_cnt[m] == SW'(m)) ? '0 : mod_cnt[m] + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- row memory
  // Same index is rewritten only one row later, past a filter byte, so the
  // write always lands before the next read of that entry.
  logic [7:0] row_mem [MAX_ROW_BYTES];
  logic [7:0] up_raw;
  logic [7:0] res_byte;
  logic       mem_wr;

  assign mem_wr = s1_adv && s1_data;

  always_ff @(posedge clk) begin
    if (take && s1_load_data)
      up_raw <= row_mem[rd_addr];
    if (mem_wr)
      row_mem[s1_addr] <= res_byte;
  end

  // ---------------------------------------------------------------- unfilter stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data     <= s1_load_data;
      s1_fault    <= load_fault;
      s1_end      <= load_end;
      s1_last     <= byte_req.last_byte;
      s1_row_done <= row_done;
      s1_byte     <= byte_req.data_byte;
      s1_filter   <= row_filter;
      s1_first    <= first_row;
      s1_left_ok  <= left_ok;
      s1_slot     <= slot_sel;
      s1_addr     <= rd_addr;
    end
  end

  logic [7:0] left_hist [MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist [MAX_PIXEL_BYTES];
  logic [7:0] left, up, upleft, pred;
  logic [8:0] avg_sum;
  logic signed [9:0] d_pa, d_pb, d_pc;
  logic [9:0] pa, pb, pc;

  always_comb begin
    up      = s1_first ? 8'd0 : up_raw;
    left    = s1_left_ok ? left_hist[s1_slot] : 8'd0;
    upleft  = (s1_left_ok && !s1_first) ? upleft_hist[s1_slot] : 8'd0;
    avg_sum = {1'b0, left} + {1'b0, up};
    // Paeth distances from p = left + up - upleft
    d_pa = $signed({2'b00, up}) - $signed({2'b00, upleft});
    d_pb = $signed({2'b00, left}) - $signed({2'b00, upleft});
    d_pc = d_pa + d_pb;
    pa   = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
    pb   = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
    pc   = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);
    case (s1_filter)
      pru_pkg::FILTER_SUB:   pred = left;
      pru_pkg::FILTER_UP:    pred = up;
      pru_pkg::FILTER_AVG:   pred = avg_sum[8:1];
      pru_pkg::FILTER_PAETH: begin
        if (pa <= pb && pa <= pc)
          pred = left;
        else if (pb <= pc)
          pred = up;
        else
          pred = upleft;
      end
      default:               pred = 8'd0;
    endcase
    res_byte = s1_byte + pred;

    if (!s1_data) begin
      res_next.pixel_byte   = 8'd0;
      res_next.end_of_image = s1_end;
      res_next.fault_code   = s1_fault;
    end else if (s1_last && !s1_row_done) begin
      res_next.pixel_byte   = 8'd0;
      res_next.end_of_image = 1'b1;
      res_next.fault_code   = pru_pkg::FAULT_ROWS;
    end else begin
      res_next.pixel_byte   = res_byte;
      res_next.end_of_image = s1_last;
      res_next.fault_code   = pru_pkg::FAULT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MAX_PIXEL_BYTES; m++) begin
        left_hist[m]   <= 8'd0;
        upleft_hist[m] <= 8'd0;
      end
    end else if (mem_wr) begin
      left_hist[s1_slot]   <= res_byte;
      upleft_hist[s1_slot] <= up;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!pixel_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv)
      out_res <= res_next;
  end

  assign pixel_valid = out_valid;
  assign pixel_res   = out_res;

  // ---------------------------------------------------------------- checks
  `CHK_NEXT(a_cfg_settle, clk, rst, cfg_wr, byte_stall, "input open right after a config write")
  `CHK_NEXT(a_discard_quiet, clk, rst, discarding && take, !s1_valid, "dropped byte reached unfilter stage")
  `CHK_NOW(a_pos_bound, clk, rst, 1'b1, CW'(byte_position) <= CW'(MAX_ROW_BYTES), "byte position past row limit")
  `CHK_NEXT(a_fault_zero, clk, rst, s1_adv && !s1_data, pixel_valid && pixel_res.pixel_byte == 8'd0 && pixel_res.fault_code != pru_pkg::FAULT_NONE, "fault result malformed")

endmodule
